[hdl/rlcd_pkg.sv]
// ----------------------------------------------------------------------------
// rlcd_pkg
// Shared types, codes and helpers of the RGB LED chain driver.
// ----------------------------------------------------------------------------
package rlcd_pkg;

	localparam int MAX_LEDS = 64;
	localparam int LED_IW   = $clog2(MAX_LEDS);
	localparam int CNT_W    = $clog2(MAX_LEDS + 1);
	localparam int WORD_W   = 24;
	localparam int BIT_W    = 5;
	localparam int TICK_W   = 16;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 16;

	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_W - 1);

	localparam logic [1:0] ACT_SET   = 2'd0;
	localparam logic [1:0] ACT_ROT   = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	localparam logic [CFG_IW-1:0] CFG_BIT_PERIOD = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ZERO_HIGH  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_ONE_HIGH   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_RESET_LOW  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_LED_COUNT  = 3'd4;

	typedef struct packed {
		logic [7:0]        bit_period;
		logic [7:0]        zero_high;
		logic [7:0]        one_high;
		logic [TICK_W-1:0] reset_low;
		logic [6:0]        led_count;
	} rlcd_cfg_t;

	typedef struct packed {
		logic wr;
		logic step;
		logic rot;
	} rlcd_cell_ctl_t;

	typedef struct packed {
		logic data_out;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} rlcd_res_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [6:0] c);
		logic [CNT_W-1:0] n;
		n = CNT_W'(c);
		if (c == 7'd0)
			n = CNT_W'(1);
		else if (32'(c) > MAX_LEDS)
			n = CNT_W'(MAX_LEDS);
		return n;
	endfunction

endpackage

[hdl/rlcd_if.sv]
// ----------------------------------------------------------------------------
// rlcd_if
// Valid/ready channels of the RGB LED chain driver: items, results, config.
// ----------------------------------------------------------------------------
interface rlcd_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [rlcd_pkg::LED_IW-1:0] led_index;
	logic [7:0]                 green;
	logic [7:0]                 red;
	logic [7:0]                 blue;

	modport source (output valid, action, led_index, green, red, blue, input ready);
	modport sink   (input valid, action, led_index, green, red, blue, output ready);
endinterface

interface rlcd_out_if;
	logic valid;
	logic ready;
	logic data_out;
	logic busy_res;
	logic frame_done;
	logic rejected;

	modport source (output valid, data_out, busy_res, frame_done, rejected, input ready);
	modport sink   (input valid, data_out, busy_res, frame_done, rejected, output ready);
endinterface

interface rlcd_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rlcd_pkg::CFG_IW-1:0] index;
	logic [rlcd_pkg::CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/rgb_led_chain_driver.sv]
// ----------------------------------------------------------------------------
// rgb_led_chain_driver
// Serial RGB LED strip driver with a ring of colour cells and a frame timer.
// ----------------------------------------------------------------------------
// Every accepted beat on the item channel yields one result beat, which is
// registered and valid in the next cycle; a tick beat is the time base of the
// waveform, so the line advances by one tick per accepted tick beat. Colours
// live in a ring of 64 cells; during a frame the ring shifts by one LED at
// each LED boundary so the cell at the head always holds the LED on the
// wire, and after the last LED the ring is back in its original order. A
// rotate moves every cell in use by one at once. Configuration is taken on
// any cycle but must be written only while no frame is in progress.
module rgb_led_chain_driver (
	input  logic       clk,
	input  logic       arst_n,
	rlcd_in_if.sink    item,
	rlcd_out_if.source result,
	rlcd_cfg_if.sink   cfg
);

	rlcd_pkg::rlcd_cfg_t                 cfg_q;
	logic [rlcd_pkg::CNT_W-1:0]          n;
	logic [rlcd_pkg::LED_IW-1:0]         last_idx;
	logic [rlcd_pkg::WORD_W-1:0]         word_q [rlcd_pkg::MAX_LEDS];
	logic [rlcd_pkg::WORD_W-1:0]         last_word;
	logic [rlcd_pkg::WORD_W-1:0]         adv_word;
	logic [rlcd_pkg::WORD_W-1:0]         set_word;
	rlcd_pkg::rlcd_cell_ctl_t            ctl;
	rlcd_pkg::rlcd_res_t                 res;
	rlcd_pkg::rlcd_res_t                 res_q;
	logic                                out_valid_q;
	logic                                fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= 8'd125;
			cfg_q.zero_high  <= 8'd40;
			cfg_q.one_high   <= 8'd80;
			cfg_q.reset_low  <= 16'd5000;
			cfg_q.led_count  <= 7'd64;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rlcd_pkg::CFG_BIT_PERIOD: cfg_q.bit_period <= cfg.data[7:0];
				rlcd_pkg::CFG_ZERO_HIGH:  cfg_q.zero_high  <= cfg.data[7:0];
				rlcd_pkg::CFG_ONE_HIGH:   cfg_q.one_high   <= cfg.data[7:0];
				rlcd_pkg::CFG_RESET_LOW:  cfg_q.reset_low  <= cfg.data[15:0];
				rlcd_pkg::CFG_LED_COUNT:  cfg_q.led_count  <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	assign item.ready = !out_valid_q || result.ready;
	assign fire       = item.valid && item.ready;

	assign n         = rlcd_pkg::eff_count(cfg_q.led_count);
	assign last_idx  = rlcd_pkg::LED_IW'(n - 7'd1);
	assign last_word = word_q[last_idx];
	assign adv_word  = (n == 7'd1) ? word_q[0] : word_q[1];
	assign set_word  = {item.green, item.red, item.blue};

	for (genvar i = 0; i < rlcd_pkg::MAX_LEDS; i++) begin : g_cell
		localparam int NXT = (i + 1) % rlcd_pkg::MAX_LEDS;
		localparam int PRV = (i + rlcd_pkg::MAX_LEDS - 1) % rlcd_pkg::MAX_LEDS;
		logic                        is_last;
		logic [rlcd_pkg::WORD_W-1:0] fwd_word;
		logic [rlcd_pkg::WORD_W-1:0] back_word;

		assign is_last   = (rlcd_pkg::CNT_W'(i) == n - 7'd1);
		assign fwd_word  = is_last ? word_q[0] : word_q[NXT];
		assign back_word = (i == 0) ? last_word : word_q[PRV];

		rlcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (item.led_index == rlcd_pkg::LED_IW'(i)),
			.in_ring   (rlcd_pkg::CNT_W'(i) < n),
			.set_word  (set_word),
			.fwd_word  (fwd_word),
			.back_word (back_word),
			.word_q    (word_q[i])
		);
	end

	rlcd_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (item.action),
		.led_index (item.led_index),
		.cfg       (cfg_q),
		.n         (n),
		.cur_word  (word_q[0]),
		.adv_word  (adv_word),
		.ctl       (ctl),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign result.valid      = out_valid_q;
	assign result.data_out   = res_q.data_out;
	assign result.busy_res   = res_q.busy_res;
	assign result.frame_done = res_q.frame_done;
	assign result.rejected   = res_q.rejected;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_done |-> !res_q.busy_res)
		else $error("frame_done while still busy");

	a_line_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.data_out |-> res_q.busy_res)
		else $error("data line high outside a frame");

	a_done_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.frame_done && res_q.rejected))
		else $error("tick beat both rejected and ending a frame");

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("accepted beat produced no result");

endmodule

[hdl/rlcd_cell.sv]
// ----------------------------------------------------------------------------
// rlcd_cell
// One colour cell of the LED ring: holds a 24-bit GRB word and loads it from
// the set data, the next cell (frame shift) or the previous cell (rotate).
// ----------------------------------------------------------------------------
module rlcd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlcd_pkg::rlcd_cell_ctl_t      ctl,
	input  logic                          sel,
	input  logic                          in_ring,
	input  logic [rlcd_pkg::WORD_W-1:0]   set_word,
	input  logic [rlcd_pkg::WORD_W-1:0]   fwd_word,
	input  logic [rlcd_pkg::WORD_W-1:0]   back_word,
	output logic [rlcd_pkg::WORD_W-1:0]   word_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctl.wr && sel) begin
			word_q <= set_word;
		end else if (ctl.step && in_ring) begin
			word_q <= fwd_word;
		end else if (ctl.rot && in_ring) begin
			word_q <= back_word;
		end
	end

endmodule

[hdl/rlcd_timer.sv]
// ----------------------------------------------------------------------------
// rlcd_timer
// Frame sequencer: reset-low timing, bit cell timing, LED and bit position,
// line level and refusal of actions.
// ----------------------------------------------------------------------------
module rlcd_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [1:0]                    action,
	input  logic [rlcd_pkg::LED_IW-1:0]   led_index,
	input  rlcd_pkg::rlcd_cfg_t           cfg,
	input  logic [rlcd_pkg::CNT_W-1:0]    n,
	input  logic [rlcd_pkg::WORD_W-1:0]   cur_word,
	input  logic [rlcd_pkg::WORD_W-1:0]   adv_word,
	output rlcd_pkg::rlcd_cell_ctl_t      ctl,
	output rlcd_pkg::rlcd_res_t           res
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RESET = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;

	logic [1:0]                     phase_q, phase_d;
	logic [rlcd_pkg::TICK_W-1:0]    tick_q, tick_d, tick_inc;
	logic [rlcd_pkg::BIT_W-1:0]     bit_q, bit_d;
	logic [rlcd_pkg::LED_IW-1:0]    led_q, led_d;
	logic [rlcd_pkg::WORD_W-1:0]    word_n;
	logic [7:0]                     high;
	logic                           busy;

	assign busy     = (phase_q != PH_IDLE);
	assign tick_inc = tick_q + 16'd1;

	always_comb begin
		phase_d        = phase_q;
		tick_d         = tick_q;
		bit_d          = bit_q;
		led_d          = led_q;
		ctl            = '0;
		res.frame_done = 1'b0;
		res.rejected   = 1'b0;
		if (fire) begin
			unique case (action)
				rlcd_pkg::ACT_TICK: begin
					unique case (phase_q)
						PH_RESET: begin
							tick_d = tick_inc;
							if (tick_inc >= cfg.reset_low) begin
								phase_d = PH_DATA;
								tick_d  = '0;
								led_d   = '0;
								bit_d   = '0;
							end
						end
						PH_DATA: begin
							tick_d = tick_inc;
							if (tick_inc >= {8'd0, cfg.bit_period}) begin
								tick_d = '0;
								if (bit_q < rlcd_pkg::BIT_LAST) begin
									bit_d = bit_q + 5'd1;
								end else begin
									bit_d    = '0;
									ctl.step = 1'b1;
									if ({1'b0, led_q} + 7'd1 >= n) begin
										phase_d        = PH_IDLE;
										led_d          = '0;
										res.frame_done = 1'b1;
									end else begin
										led_d = led_q + 6'd1;
									end
								end
							end
						end
						default: ;
					endcase
				end
				rlcd_pkg::ACT_SET: begin
					if (busy || {1'b0, led_index} >= n)
						res.rejected = 1'b1;
					else
						ctl.wr = 1'b1;
				end
				rlcd_pkg::ACT_ROT: begin
					if (busy)
						res.rejected = 1'b1;
					else
						ctl.rot = 1'b1;
				end
				rlcd_pkg::ACT_START: begin
					if (busy) begin
						res.rejected = 1'b1;
					end else begin
						phase_d = PH_RESET;
						tick_d  = '0;
						led_d   = '0;
						bit_d   = '0;
					end
				end
				default: ;
			endcase
		end
		word_n       = ctl.step ? adv_word : cur_word;
		high         = word_n[rlcd_pkg::BIT_LAST - bit_d] ? cfg.one_high : cfg.zero_high;
		res.data_out = (phase_d == PH_DATA) && (tick_d < {8'd0, high});
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			led_q   <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			led_q   <= led_d;
		end
	end

endmodule

[tb/rgb_led_chain_driver_tb.sv]
// ----------------------------------------------------------------------------
// rgb_led_chain_driver_tb
// Self-checking bench for the RGB LED chain driver. A strip predictor tracks
// the colour store, the frame timer and the timing registers, and computes
// the line state that each item beat must produce. Result beats are compared
// field by field in order. Directed tests cover refused actions, bad indexes,
// odd timings and the LED count limits. A random phase runs many short frames
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module rgb_led_chain_driver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_MAX     = 16;
	localparam int RANDOM_BEATS = 500;
	localparam int CFG_SPARE_LO = 5;
	localparam int CFG_SPARE_HI = 7;

	typedef enum logic [1:0] {FP_IDLE, FP_RESET, FP_DATA} frame_phase_t;

	logic clk;
	logic arst_n;

	rlcd_in_if  item_ch ();
	rlcd_out_if result_ch ();
	rlcd_cfg_if cfg_ch ();

	rgb_led_chain_driver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// strip predictor state
	rlcd_pkg::rlcd_cfg_t          cfg_now;
	logic [rlcd_pkg::WORD_W-1:0]  pix [rlcd_pkg::MAX_LEDS];
	frame_phase_t                 phase;
	int                           led_pos;
	int                           bit_pos;
	logic [rlcd_pkg::TICK_W-1:0]  tick_cnt;

	rlcd_pkg::rlcd_res_t line_state_q [$];

	int errors = 0;
	int beats_sent = 0;
	int tx_gap_max = IDLE_MAX;
	int rx_stall_max = IDLE_MAX;
	int rx_hold_req = 0;
	bit offering = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int leds_in_use();
		if (cfg_now.led_count == 7'd0)
			return 1;
		if (int'(cfg_now.led_count) > rlcd_pkg::MAX_LEDS)
			return rlcd_pkg::MAX_LEDS;
		return int'(cfg_now.led_count);
	endfunction

	function automatic rlcd_pkg::rlcd_res_t next_line_state(input logic [1:0] act,
		input logic [rlcd_pkg::LED_IW-1:0] idx, input logic [rlcd_pkg::WORD_W-1:0] grb);
		rlcd_pkg::rlcd_res_t         r;
		int                          n;
		logic                        busy;
		logic [rlcd_pkg::WORD_W-1:0] last;
		logic [7:0]                  hi;
		r = '0;
		n = leds_in_use();
		busy = (phase != FP_IDLE);
		if (act == rlcd_pkg::ACT_TICK) begin
			if (phase == FP_RESET) begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= cfg_now.reset_low) begin
					phase = FP_DATA;
					tick_cnt = '0;
					led_pos = 0;
					bit_pos = 0;
				end
			end else if (phase == FP_DATA) begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= rlcd_pkg::TICK_W'(cfg_now.bit_period)) begin
					tick_cnt = '0;
					if (bit_pos < rlcd_pkg::WORD_W - 1) begin
						bit_pos++;
					end else begin
						bit_pos = 0;
						if (led_pos + 1 >= n) begin
							phase = FP_IDLE;
							led_pos = 0;
							r.frame_done = 1'b1;
						end else begin
							led_pos++;
						end
					end
				end
			end
		end else if (busy) begin
			r.rejected = 1'b1;
		end else if (act == rlcd_pkg::ACT_SET) begin
			if (int'(idx) < n)
				pix[idx] = grb;
			else
				r.rejected = 1'b1;
		end else if (act == rlcd_pkg::ACT_ROT) begin
			last = pix[n-1];
			for (int i = n - 1; i > 0; i--)
				pix[i] = pix[i-1];
			pix[0] = last;
		end else begin
			phase = FP_RESET;
			tick_cnt = '0;
			led_pos = 0;
			bit_pos = 0;
		end
		if (phase == FP_DATA) begin
			hi = pix[led_pos][rlcd_pkg::WORD_W-1-bit_pos] ?
				cfg_now.one_high : cfg_now.zero_high;
			r.data_out = (tick_cnt < rlcd_pkg::TICK_W'(hi));
		end
		r.busy_res = (phase != FP_IDLE);
		return r;
	endfunction

	task automatic send_cmd(input logic [1:0] act, input logic [rlcd_pkg::LED_IW-1:0] idx,
		input logic [rlcd_pkg::WORD_W-1:0] grb);
		int gap;
		gap = tx_gap_max > 0 ? $urandom_range(0, tx_gap_max) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.action    <= act;
		item_ch.led_index <= idx;
		item_ch.green     <= grb[23:16];
		item_ch.red       <= grb[15:8];
		item_ch.blue      <= grb[7:0];
		offering = 1'b1;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		line_state_q.push_back(next_line_state(act, idx, grb));
		beats_sent++;
	endtask

	task automatic settle();
		if (offering) begin
			item_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (line_state_q.size() != 0) @(posedge clk);
	endtask

	task automatic run_frame(input int noise_one_in);
		send_cmd(rlcd_pkg::ACT_START, rlcd_pkg::LED_IW'($urandom),
			rlcd_pkg::WORD_W'($urandom));
		while (phase != FP_IDLE) begin
			if (noise_one_in > 0 && $urandom_range(1, noise_one_in) == 1)
				send_cmd(2'($urandom_range(rlcd_pkg::ACT_SET, rlcd_pkg::ACT_START)),
					rlcd_pkg::LED_IW'($urandom), rlcd_pkg::WORD_W'($urandom));
			else
				send_cmd(rlcd_pkg::ACT_TICK, rlcd_pkg::LED_IW'($urandom),
					rlcd_pkg::WORD_W'($urandom));
		end
	endtask

	task automatic load_config(input logic [7:0] per, input logic [7:0] zhi,
		input logic [7:0] ohi, input logic [rlcd_pkg::TICK_W-1:0] rlow,
		input logic [6:0] leds);
		logic [rlcd_pkg::CFG_IW-1:0] reg_id [6];
		logic [rlcd_pkg::CFG_DW-1:0] val [6];
		int                          n;
		while (phase != FP_IDLE)
			send_cmd(rlcd_pkg::ACT_TICK, rlcd_pkg::LED_IW'($urandom),
				rlcd_pkg::WORD_W'($urandom));
		settle();
		reg_id[0] = rlcd_pkg::CFG_BIT_PERIOD;
		val[0]    = {8'($urandom), per};
		reg_id[1] = rlcd_pkg::CFG_ZERO_HIGH;
		val[1]    = {8'($urandom), zhi};
		reg_id[2] = rlcd_pkg::CFG_ONE_HIGH;
		val[2]    = {8'($urandom), ohi};
		reg_id[3] = rlcd_pkg::CFG_RESET_LOW;
		val[3]    = rlow;
		reg_id[4] = rlcd_pkg::CFG_LED_COUNT;
		val[4]    = {9'($urandom), leds};
		n = 5;
		if ($urandom_range(0, 3) == 0) begin
			reg_id[5] = rlcd_pkg::CFG_IW'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
			val[5]    = rlcd_pkg::CFG_DW'($urandom);
			n = 6;
		end
		for (int i = 0; i < n; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= reg_id[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		end
		cfg_ch.valid <= 1'b0;
		cfg_now.bit_period = per;
		cfg_now.zero_high  = zhi;
		cfg_now.one_high   = ohi;
		cfg_now.reset_low  = rlow;
		cfg_now.led_count  = leds;
	endtask

	task automatic rand_config();
		logic [7:0] per;
		logic [6:0] leds;
		int         sel;
		per  = 8'($urandom_range(0, 3));
		leds = 7'($urandom_range(0, 2));
		sel  = $urandom_range(0, 31);
		if (sel < 4)
			leds = 7'($urandom_range(3, 12));
		load_config(per, 8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
			rlcd_pkg::TICK_W'($urandom_range(0, 12)), leds);
	endtask

	task automatic check_bit(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s expected %0b actual %0b", $time, name, want, got);
			errors++;
		end
	endtask

	// result channel: random stalls plus an occasional long hold-off
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_hold_req + (rx_stall_max > 0 ? $urandom_range(0, rx_stall_max) : 0);
			rx_hold_req = 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk);
			while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
		end
	end

	initial begin
		rlcd_pkg::rlcd_res_t want;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (line_state_q.size() == 0) begin
					$display("%0t: result beat with nothing pending", $time);
					errors++;
				end else begin
					want = line_state_q.pop_front();
					check_bit("data_out", want.data_out, result_ch.data_out);
					check_bit("busy_res", want.busy_res, result_ch.busy_res);
					check_bit("frame_done", want.frame_done, result_ch.frame_done);
					check_bit("rejected", want.rejected, result_ch.rejected);
				end
			end
		end
	end

	task automatic test_idle_actions();
		send_cmd(rlcd_pkg::ACT_TICK, '0, '0);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(0), 24'hFF_FF_FF);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(rlcd_pkg::MAX_LEDS - 1), 24'h00_00_00);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(rlcd_pkg::MAX_LEDS - 1), 24'hFF_FF_FF);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(1), 24'hA5_5A_C3);
		send_cmd(rlcd_pkg::ACT_ROT, '1, '1);
		send_cmd(rlcd_pkg::ACT_TICK, '1, '1);
	endtask

	// short two-LED frame with refused actions sprinkled in
	task automatic test_default_frame();
		tx_gap_max = 0;
		rx_stall_max = 0;
		load_config(8'd4, 8'd1, 8'd3, 16'd6, 7'd2);
		run_frame(20);
	endtask

	task automatic test_bad_index();
		tx_gap_max = IDLE_MAX;
		rx_stall_max = IDLE_MAX;
		load_config(8'd2, 8'd1, 8'd1, 16'd3, 7'd3);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(2), 24'h12_34_56);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(3), 24'h65_43_21);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(rlcd_pkg::MAX_LEDS - 1), 24'hFF_00_FF);
		send_cmd(rlcd_pkg::ACT_ROT, '0, '0);
		run_frame(4);
		load_config(8'd1, 8'd0, 8'd1, 16'd2, 7'd0);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(1), 24'h00_FF_00);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(0), 24'h80_01_7F);
		send_cmd(rlcd_pkg::ACT_ROT, '0, '0);
		run_frame(0);
		tx_gap_max = 0;
		load_config(8'd1, 8'd1, 8'd0, 16'd1, 7'd100);
		send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(rlcd_pkg::MAX_LEDS - 1), 24'h0F_F0_3C);
		send_cmd(rlcd_pkg::ACT_ROT, '0, '0);
	endtask

	task automatic test_odd_timing();
		tx_gap_max = IDLE_MAX;
		rx_stall_max = IDLE_MAX;
		load_config(8'd0, 8'd0, 8'd255, 16'd0, 7'd1);
		run_frame(0);
		load_config(8'd1, 8'd5, 8'd1, 16'd1, 7'd2);
		run_frame(3);
		tx_gap_max = 0;
		rx_stall_max = 0;
		load_config(8'd3, 8'd254, 8'd1, 16'd2, 7'd1);
		run_frame(0);
		load_config(8'd2, 8'd1, 8'd2, 16'd100, 7'd1);
		run_frame(0);
	endtask

	// fill every LED, rotate the whole strip twice, then show its head
	task automatic test_full_strip();
		tx_gap_max = IDLE_MAX;
		rx_stall_max = IDLE_MAX;
		load_config(8'd2, 8'd1, 8'd2, 16'd1, 7'd64);
		for (int i = 0; i < rlcd_pkg::MAX_LEDS; i++)
			send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'(i), rlcd_pkg::WORD_W'($urandom));
		send_cmd(rlcd_pkg::ACT_ROT, '0, '0);
		send_cmd(rlcd_pkg::ACT_ROT, '0, '0);
		load_config(8'd1, 8'd0, 8'd1, 16'd1, 7'd4);
		run_frame(16);
	endtask

	// hold the result side off while items keep coming, then drain
	task automatic test_backpressure();
		tx_gap_max = 0;
		rx_stall_max = 0;
		load_config(8'd1, 8'd1, 8'd2, 16'd2, 7'd1);
		rx_hold_req = 100;
		repeat (60)
			send_cmd(2'($urandom), rlcd_pkg::LED_IW'($urandom), rlcd_pkg::WORD_W'($urandom));
		settle();
		run_frame(0);
	endtask

	task automatic test_random_traffic();
		int first;
		int nprep;
		int pick;
		first = beats_sent;
		while (beats_sent - first < RANDOM_BEATS) begin
			if ($urandom_range(0, 2) == 0)
				rand_config();
			tx_gap_max = $urandom_range(0, 3) == 0 ? 0 : IDLE_MAX;
			rx_stall_max = $urandom_range(0, 3) == 0 ? 0 : IDLE_MAX;
			nprep = $urandom_range(0, 10);
			repeat (nprep) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					send_cmd(rlcd_pkg::ACT_SET, rlcd_pkg::LED_IW'($urandom_range(0, 3) != 0 ?
						$urandom_range(0, leds_in_use() - 1) :
						$urandom_range(0, rlcd_pkg::MAX_LEDS - 1)),
						rlcd_pkg::WORD_W'($urandom));
				else if (pick < 8)
					send_cmd(rlcd_pkg::ACT_ROT, rlcd_pkg::LED_IW'($urandom),
						rlcd_pkg::WORD_W'($urandom));
				else if (pick == 8)
					send_cmd(rlcd_pkg::ACT_TICK, rlcd_pkg::LED_IW'($urandom),
						rlcd_pkg::WORD_W'($urandom));
				else
					send_cmd(2'($urandom), rlcd_pkg::LED_IW'($urandom),
						rlcd_pkg::WORD_W'($urandom));
			end
			run_frame(8);
		end
	endtask

	initial begin
		cfg_now.bit_period = 8'd125;
		cfg_now.zero_high  = 8'd40;
		cfg_now.one_high   = 8'd80;
		cfg_now.reset_low  = 16'd5000;
		cfg_now.led_count  = 7'd64;
		foreach (pix[i])
			pix[i] = '0;
		phase    = FP_IDLE;
		led_pos  = 0;
		bit_pos  = 0;
		tick_cnt = '0;

		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.action    <= rlcd_pkg::ACT_TICK;
		item_ch.led_index <= '0;
		item_ch.green     <= '0;
		item_ch.red       <= '0;
		item_ch.blue      <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= rlcd_pkg::CFG_BIT_PERIOD;
		cfg_ch.data       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_actions();
		test_default_frame();
		test_bad_index();
		test_odd_timing();
		test_full_strip();
		test_backpressure();
		test_random_traffic();

		settle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[rgb_led_chain_driver.f]
hdl/rlcd_pkg.sv
hdl/rlcd_if.sv
hdl/rlcd_cell.sv
hdl/rlcd_timer.sv
hdl/rgb_led_chain_driver.sv
tb/rgb_led_chain_driver_tb.sv
